// ===== sv/fsp_pkg.sv =====
package fsp_pkg;

    // default configuration
    localparam int NUM_PORTS_DEF = 2;
    localparam int NUM_SLOTS_DEF = 513;

    // frame delimiters
    localparam logic [7:0] MAGIC_FIRST  = 8'h44;
    localparam logic [7:0] MAGIC_SECOND = 8'h4D;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int SLOT_W = 10;
    localparam int LEN_W  = 10;

    // widest values the parameter ranges allow
    localparam int PORT_W_MAX = 4;
    localparam int LEN_W_MAX  = 11;

    // input action codes
    localparam logic ACTION_FEED = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // result kind codes
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // staging buffer write from the parser
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } stage_wr_t;

    // frame complete, copy staging into the port store
    typedef struct packed {
        logic                 valid;
        logic [PORT_W_MAX-1:0] port;
        logic [LEN_W_MAX-1:0]  len;
    } commit_t;

endpackage

// ===== sv/fsp_if.sv =====
interface fsp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [fsp_pkg::BYTE_W-1:0]    rx_byte;
    logic                          req_port;
    logic [fsp_pkg::SLOT_W-1:0]    read_slot;

    modport source (output valid, action, rx_byte, req_port, read_slot, input ready);
    modport sink   (input valid, action, rx_byte, req_port, read_slot, output ready);
endinterface

interface fsp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic                          port_number;
    logic [fsp_pkg::LEN_W-1:0]     frame_length;
    logic [fsp_pkg::BYTE_W-1:0]    slot_value;

    modport source (output valid, result_kind, port_number, frame_length, slot_value,
                    input ready);
    modport sink   (input valid, result_kind, port_number, frame_length, slot_value,
                    output ready);
endinterface

// ===== sv/fsp_ram.sv =====
module fsp_ram #(
    parameter int DEPTH = fsp_pkg::NUM_SLOTS_DEF,
    parameter int WIDTH = fsp_pkg::BYTE_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/fsp_parser.sv =====
module fsp_parser #(
    parameter int NUM_PORTS = fsp_pkg::NUM_PORTS_DEF,
    parameter int NUM_SLOTS = fsp_pkg::NUM_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    input  logic [fsp_pkg::BYTE_W-1:0] rx_byte,
    output fsp_pkg::stage_wr_t         stage_wr,
    output fsp_pkg::commit_t           commit
);

    localparam int LW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_MAGIC2  = 6'b000010,
        PH_PORT    = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_LEN_HI  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      frame_port_reg, frame_port_next;
    logic [7:0]      len_lo_reg, len_lo_next;
    logic [LW-1:0]   frame_len_reg, frame_len_next;
    logic [LW-1:0]   fill_count_reg, fill_count_next;
    logic [15:0]     len_full;
    logic            frame_ok;
    logic [LW-1:0]   fill_inc;
    logic            payload_wr;
    logic            last_byte;

    assign len_full   = {rx_byte, len_lo_reg};
    assign frame_ok   = (frame_port_reg < 8'(NUM_PORTS)) && (len_full != 16'd0)
                        && (len_full <= 16'(NUM_SLOTS));
    assign fill_inc   = fill_count_reg + LW'(1);
    assign payload_wr = byte_valid && (phase_reg == PH_PAYLOAD);
    assign last_byte  = (fill_inc == frame_len_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        frame_port_next = frame_port_reg;
        len_lo_next     = len_lo_reg;
        frame_len_next  = frame_len_reg;
        fill_count_next = fill_count_reg;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    phase_next = (rx_byte == fsp_pkg::MAGIC_FIRST) ? PH_MAGIC2 : PH_HUNT;
                end
                PH_MAGIC2:
                begin
                    phase_next = (rx_byte == fsp_pkg::MAGIC_SECOND) ? PH_PORT : PH_HUNT;
                end
                PH_PORT:
                begin
                    frame_port_next = rx_byte;
                    phase_next      = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if (frame_ok)
                    begin
                        frame_len_next  = LW'(len_full);
                        fill_count_next = '0;
                        phase_next      = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    fill_count_next = fill_inc;
                    if (last_byte)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            frame_port_reg <= '0;
            len_lo_reg     <= '0;
            frame_len_reg  <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_port_reg <= frame_port_next;
            len_lo_reg     <= len_lo_next;
            frame_len_reg  <= frame_len_next;
            fill_count_reg <= fill_count_next;
        end
    end

    assign stage_wr.en   = payload_wr;
    assign stage_wr.addr = fsp_pkg::SLOT_W'(fill_count_reg);
    assign stage_wr.data = rx_byte;

    assign commit.valid = payload_wr && last_byte;
    assign commit.port  = fsp_pkg::PORT_W_MAX'(frame_port_reg);
    assign commit.len   = fsp_pkg::LEN_W_MAX'(frame_len_reg);

endmodule

// ===== sv/framed_serial_to_slot_buffer_parser.sv =====
// channel   dir  handshake     payload
// feed      in   valid/ready   action, rx_byte, req_port, read_slot
// result    out  valid/ready   result_kind, port_number, frame_length, slot_value
//
// a slot read goes through a store read, then a result load
// the last payload byte starts a copy of the staging buffer into the port store,
// one slot per cycle through the single store write port
// reset clears control state only; unwritten store slots read as zero through a
// per-port high-water mark, so there is no clearing pass
// a full result register holds the step that loads it; feeding waits until it is loaded
module framed_serial_to_slot_buffer_parser #(
    parameter int NUM_PORTS = fsp_pkg::NUM_PORTS_DEF,
    parameter int NUM_SLOTS = fsp_pkg::NUM_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fsp_in_if.sink       feed,
    fsp_out_if.source    result
);

    localparam int LW          = $clog2(NUM_SLOTS + 1);
    localparam int PW          = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int STAGE_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STORE_DEPTH = NUM_PORTS * NUM_SLOTS;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_COPY  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_ACK   = 5'b10000
    } ctrl_state_t;

    ctrl_state_t               state_reg, state_next;

    // parser side
    logic                      feed_accept;
    logic                      byte_valid;
    fsp_pkg::stage_wr_t        stage_wr;
    fsp_pkg::commit_t          commit;

    // per-port length and high-water mark of written slots
    logic [LW-1:0]             port_length_reg [NUM_PORTS];
    logic [LW-1:0]             hiwater_reg [NUM_PORTS];

    // slot read path
    logic                      rd_accept;
    logic                      port_ok;
    logic [PW-1:0]             rd_pidx;
    logic                      rd_hit;
    logic                      rd_port_reg;
    logic [fsp_pkg::LEN_W-1:0] rd_len_reg;
    logic                      rd_hit_reg;

    // copy sequencer
    logic [PW-1:0]             copy_port_reg;
    logic [LW-1:0]             copy_len_reg;
    logic [STORE_AW-1:0]       copy_base_reg;
    logic [LW-1:0]             cnt_reg, cnt_next;
    logic [LW-1:0]             cnt_inc;
    logic                      wr_pend_reg, wr_pend_next;
    logic [LW-1:0]             wr_idx_reg;

    // memories
    logic                      stage_rd_en;
    logic [fsp_pkg::BYTE_W-1:0] stage_rd_data;
    logic                      store_rd_en;
    logic [STORE_AW-1:0]       store_rd_addr;
    logic [STORE_AW-1:0]       store_wr_addr;
    logic [fsp_pkg::BYTE_W-1:0] store_rd_data;

    // result register
    logic                      out_valid_reg;
    logic                      out_kind_reg;
    logic                      out_port_reg;
    logic [fsp_pkg::LEN_W-1:0] out_len_reg;
    logic [fsp_pkg::BYTE_W-1:0] out_value_reg;
    logic                      out_free;
    logic                      load_read;
    logic                      load_ack;

    assign feed.ready  = (state_reg == ST_IDLE);
    assign feed_accept = feed.valid && feed.ready;
    assign byte_valid  = feed_accept && (feed.action == fsp_pkg::ACTION_FEED);
    assign rd_accept   = feed_accept && (feed.action == fsp_pkg::ACTION_READ);

    fsp_parser #(
        .NUM_PORTS (NUM_PORTS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (feed.rx_byte),
        .stage_wr   (stage_wr),
        .commit     (commit)
    );

    // staging buffer: parser writes, copy sequencer reads
    fsp_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (fsp_pkg::BYTE_W)
    ) u_stage (
        .clk     (clk),
        .wr_en   (stage_wr.en),
        .wr_addr (stage_wr.addr[STAGE_AW-1:0]),
        .wr_data (stage_wr.data),
        .rd_en   (stage_rd_en),
        .rd_addr (cnt_reg[STAGE_AW-1:0]),
        .rd_data (stage_rd_data)
    );

    // port store: copy writes, slot reads; the sequencer keeps them apart in time
    fsp_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (fsp_pkg::BYTE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (store_wr_addr),
        .wr_data (stage_rd_data),
        .rd_en   (store_rd_en),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data)
    );

    // slot read decode; a slot at or past the high-water mark was never written
    assign port_ok       = (NUM_PORTS > 1) || (feed.req_port == 1'b0);
    assign rd_pidx       = port_ok ? PW'(feed.req_port) : '0;
    assign rd_hit        = port_ok
                           && ({1'b0, feed.read_slot}
                               < (fsp_pkg::SLOT_W + 1)'(hiwater_reg[rd_pidx]));
    assign store_rd_en   = rd_accept && rd_hit;
    assign store_rd_addr = STORE_AW'(rd_pidx) * STORE_AW'(NUM_SLOTS) + STORE_AW'(feed.read_slot);

    // copy: read staging slot n, write it to the store in the next cycle
    assign stage_rd_en   = (state_reg == ST_COPY);
    assign cnt_inc       = cnt_reg + LW'(1);
    assign store_wr_addr = copy_base_reg + STORE_AW'(wr_idx_reg);

    assign out_free  = !out_valid_reg || result.ready;
    assign load_read = (state_reg == ST_READ) && out_free;
    assign load_ack  = (state_reg == ST_ACK) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        wr_pend_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (commit.valid)
                begin
                    cnt_next   = '0;
                    state_next = ST_COPY;
                end
                else if (rd_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                wr_pend_next = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_inc == copy_len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                port_length_reg[i] <= LW'(NUM_SLOTS);
                hiwater_reg[i]     <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= wr_pend_next;

            // the final store write lands this cycle; the new length goes live with it
            if (state_reg == ST_DRAIN)
            begin
                port_length_reg[copy_port_reg] <= copy_len_reg;
                if (copy_len_reg > hiwater_reg[copy_port_reg])
                begin
                    hiwater_reg[copy_port_reg] <= copy_len_reg;
                end
            end

            if (load_read || load_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (commit.valid && (state_reg == ST_IDLE))
        begin
            copy_port_reg <= commit.port[PW-1:0];
            copy_len_reg  <= commit.len[LW-1:0];
            copy_base_reg <= STORE_AW'(commit.port[PW-1:0]) * STORE_AW'(NUM_SLOTS);
        end
        if (state_reg == ST_COPY)
        begin
            wr_idx_reg <= cnt_reg;
        end
        if (rd_accept)
        begin
            rd_port_reg <= feed.req_port;
            rd_len_reg  <= port_ok ? fsp_pkg::LEN_W'(port_length_reg[rd_pidx]) : '0;
            rd_hit_reg  <= rd_hit;
        end
        if (load_read)
        begin
            out_kind_reg  <= fsp_pkg::KIND_READ;
            out_port_reg  <= rd_port_reg;
            out_len_reg   <= rd_len_reg;
            out_value_reg <= rd_hit_reg ? store_rd_data : '0;
        end
        else if (load_ack)
        begin
            out_kind_reg  <= fsp_pkg::KIND_ACK;
            out_port_reg  <= copy_port_reg[0];
            out_len_reg   <= fsp_pkg::LEN_W'(copy_len_reg);
            out_value_reg <= '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.port_number  = out_port_reg;
    assign result.frame_length = out_len_reg;
    assign result.slot_value   = out_value_reg;

endmodule
